>>> rtl/trs_pkg.sv
// shared types, constants and helper function for the taylor sine block
package trs_pkg;

    // 2*pi in unsigned Q3.60
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

    localparam int WORK_FRAC = 28;
    localparam logic [31:0] ONE = 32'd1 << WORK_FRAC;

    localparam int V_W  = 65;
    localparam int N_W  = 4;
    localparam int XM_W = 31;

    localparam logic [N_W-1:0] TERM_COUNT_RESET = 4'd5;

    // 1/((2k)(2k+1)) in unsigned Q32, rounded to nearest, for k = 1 .. 11
    localparam logic [31:0] RECIP_Q32 [0:10] = '{
        32'd715827883, 32'd214748365, 32'd102261126, 32'd59652324,
        32'd39045157,  32'd27531842,  32'd20452225,  32'd15790321,
        32'd12558384,  32'd10226113,  32'd8488078
    };

    // word moving through the reduction chain
    typedef struct packed {
        logic           valid;
        logic [N_W-1:0] n;
        logic [V_W-1:0] v;
    } t_red_bus;

    // word moving through the series chain; s is signed Q28
    typedef struct packed {
        logic              valid;
        logic [N_W-1:0]    n;
        logic              x_neg;
        logic [XM_W-1:0]   x_mag;
        logic [31:0]       x2;
        logic signed [31:0] s;
    } t_term_bus;

    // right shift with rounding of the magnitude, halves up
    function automatic logic [63:0] shr_round_u64(input logic [63:0] v, input int s);
        logic [63:0] q;
        q = v;
        if (s > 0) begin
            q = (v >> s) + ((v >> (s - 1)) & 64'd1);
        end
        return q;
    endfunction

endpackage

>>> rtl/trs_red_cell.sv
// one conditional-subtract cell of the angle reduction chain
module trs_red_cell #(
    parameter logic [64:0] MODULUS = 65'd1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  trs_pkg::t_red_bus i_bus,
    output trs_pkg::t_red_bus o_bus
);

    trs_pkg::t_red_bus r_bus;
    logic              ge;

    assign ge = (i_bus.v >= MODULUS);

    always_ff @(posedge i_clk) begin
        r_bus <= i_bus;
        if (ge) begin
            r_bus.v <= i_bus.v - MODULUS;
        end
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end
    end

    assign o_bus = r_bus;

endmodule

>>> rtl/trs_term_cell.sv
// one nested series cell: s_out = 1 - (x^2 / ((2k)(2k+1))) * s_in, three stages
module trs_term_cell #(
    parameter int K = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  trs_pkg::t_term_bus i_bus,
    output trs_pkg::t_term_bus o_bus
);

    localparam logic [31:0] RECIP = trs_pkg::RECIP_Q32[K-1];

    trs_pkg::t_term_bus r_a;
    trs_pkg::t_term_bus r_b;
    trs_pkg::t_term_bus r_c;
    logic [63:0]        r_pg;
    logic [63:0]        r_mg;

    logic [31:0]        g;
    logic [31:0]        s_abs;
    logic [35:0]        t;
    logic [35:0]        s_new;
    logic               active;
    logic signed [31:0] n_s;

    // stage a: x^2 times the factor
    always_ff @(posedge i_clk) begin
        r_a  <= i_bus;
        r_pg <= 64'(i_bus.x2) * 64'(RECIP);
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end
    end

    // stage b: round the factor product, multiply by |s|
    always_comb begin
        g     = r_pg[63:32] + 32'(r_pg[31]);
        s_abs = r_a.s[31] ? 32'(-r_a.s) : 32'(r_a.s);
    end

    always_ff @(posedge i_clk) begin
        r_b  <= r_a;
        r_mg <= 64'(g) * 64'(s_abs);
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end
    end

    // stage c: one minus the rounded product; cells past the term count pass s on
    always_comb begin
        t      = 36'(r_mg[63:28]) + 36'(r_mg[27]);
        s_new  = r_b.s[31] ? (36'(trs_pkg::ONE) + t) : (36'(trs_pkg::ONE) - t);
        active = (trs_pkg::N_W'(K) < r_b.n);
        n_s    = active ? $signed(s_new[31:0]) : r_b.s;
    end

    always_ff @(posedge i_clk) begin
        r_c   <= r_b;
        r_c.s <= n_s;
        if (!i_rst_n) begin
            r_c.valid <= 1'b0;
        end
    end

    assign o_bus = r_c;

endmodule

>>> rtl/taylor_sine_with_range_reduction_top.sv
// top level: range reduction, series chain and output rounding for the taylor sine
// Takes one Q11.20 angle per clock cycle whenever busy is low (busy is high only in
// reset) and returns its sine in Q1.16, saturated to +-1, on o_sine with a one-cycle
// o_strobe. The result is registered through the input stage, the R reduction cells
// (R is 66 minus the bit length of 2*pi at the angle scale, 11 at 20 fraction bits),
// the fold, rounding and squaring stages, the series cells, the product stage and the
// output register. The two cell chains do one conditional subtract of
// 2*pi per reduction cell and one multiply-round stage pair plus an update stage per
// series cell. The receiver cannot stall and none is needed: every accepted angle
// leaves exactly one result. term_count is taken with each angle at the input, is
// clamped to 1..MAX_TERMS, and should be written only while no angle is in flight.
module taylor_sine_with_range_reduction_top #(
    parameter int MAX_TERMS       = 8,
    parameter int ANGLE_FRAC_BITS = 20,
    parameter int OUT_FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [3:0]                    i_cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [31:0]            i_angle,
    output logic                          o_strobe,
    output logic signed [OUT_FRAC_BITS+1:0] o_sine
);

    localparam int OUT_W  = OUT_FRAC_BITS + 2;
    localparam int RED_SH = 28 - ANGLE_FRAC_BITS;
    localparam int X_SH   = ANGLE_FRAC_BITS + 32 - trs_pkg::WORK_FRAC;
    localparam int Y_SH   = 2 * trs_pkg::WORK_FRAC - OUT_FRAC_BITS;
    localparam int NCELL  = MAX_TERMS - 1;

    localparam logic [63:0] TWO_PI = trs_pkg::shr_round_u64(trs_pkg::TWO_PI_Q60, RED_SH);
    localparam logic [63:0] PI     = trs_pkg::shr_round_u64(trs_pkg::TWO_PI_Q60, RED_SH + 1);

    // bias by a multiple of 2*pi so that every angle becomes non-negative
    localparam logic [127:0] OFF_MULT = ((128'd1 << 63) + 128'(TWO_PI) - 128'd1)
                                        / 128'(TWO_PI);
    localparam logic [127:0] OFF_WIDE = OFF_MULT * 128'(TWO_PI);
    localparam logic [64:0]  OFFSET   = OFF_WIDE[64:0];

    localparam int RED_STAGES = 66 - $clog2(TWO_PI);
    localparam int LAT        = 7 + RED_STAGES + 3 * NCELL;

    localparam logic [63:0] X_LIM_W = (PI >> X_SH) + 64'd1;
    localparam logic [trs_pkg::XM_W-1:0] X_LIM = X_LIM_W[trs_pkg::XM_W-1:0];
    localparam logic [62:0] LIM = 63'd1 << OUT_FRAC_BITS;

    logic                      r_busy;
    logic [trs_pkg::N_W-1:0]   r_term_count;
    logic [trs_pkg::N_W-1:0]   n_clamped;
    logic                      accept;

    trs_pkg::t_red_bus         r_in;
    trs_pkg::t_red_bus         red_bus [0:RED_STAGES];

    logic                      r_f1_valid;
    logic [trs_pkg::N_W-1:0]   r_f1_n;
    logic                      r_f1_neg;
    logic [63:0]               r_f1_mag;
    logic                      f1_wrap;

    trs_pkg::t_term_bus        r_f2;
    trs_pkg::t_term_bus        r_sq1;
    logic [61:0]               r_sq_p;
    trs_pkg::t_term_bus        r_sq2;
    trs_pkg::t_term_bus        term_bus [0:NCELL];

    logic [31:0]               fin_s_abs;
    logic                      r_fa_valid;
    logic                      r_fa_neg;
    logic [62:0]               r_fa_p;
    logic [62:0]               ym;
    logic [OUT_W-1:0]          sat_m;
    logic [OUT_W-1:0]          n_sine;

    logic                      r_strobe;
    logic [OUT_W-1:0]          r_sine;

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= trs_pkg::TERM_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_term_count <= i_cfg_wdata;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    always_comb begin
        priority if (r_term_count == '0) begin
            n_clamped = trs_pkg::N_W'(1);
        end else if (r_term_count > trs_pkg::N_W'(MAX_TERMS)) begin
            n_clamped = trs_pkg::N_W'(MAX_TERMS);
        end else begin
            n_clamped = r_term_count;
        end
    end

    // input stage: angle scaled by 2^32 plus the bias
    always_ff @(posedge i_clk) begin
        r_in.valid <= accept;
        r_in.n     <= n_clamped;
        r_in.v     <= {i_angle[31], i_angle, 32'd0} + OFFSET;
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end
    end

    assign red_bus[0] = r_in;

    for (genvar j = 0; j < RED_STAGES; j++) begin : g_red
        localparam logic [64:0] MOD_J = 65'(TWO_PI) << (RED_STAGES - 1 - j);
        trs_red_cell #(
            .MODULUS(MOD_J)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_bus  (red_bus[j]),
            .o_bus  (red_bus[j+1])
        );
    end

    // fold [0, 2pi) onto [-pi, pi) as sign and magnitude
    assign f1_wrap = (red_bus[RED_STAGES].v >= 65'(PI));

    always_ff @(posedge i_clk) begin
        r_f1_n   <= red_bus[RED_STAGES].n;
        r_f1_neg <= f1_wrap;
        r_f1_mag <= f1_wrap ? 64'(65'(TWO_PI) - red_bus[RED_STAGES].v)
                            : red_bus[RED_STAGES].v[63:0];
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= red_bus[RED_STAGES].valid;
        end
    end

    // round to Q28
    always_ff @(posedge i_clk) begin
        r_f2.valid <= r_f1_valid;
        r_f2.n     <= r_f1_n;
        r_f2.x_neg <= r_f1_neg;
        r_f2.x_mag <= trs_pkg::XM_W'(r_f1_mag >> X_SH) + trs_pkg::XM_W'(r_f1_mag[X_SH-1]);
        r_f2.x2    <= '0;
        r_f2.s     <= $signed(trs_pkg::ONE);
        if (!i_rst_n) begin
            r_f2.valid <= 1'b0;
        end
    end

    // x^2 in two stages
    always_ff @(posedge i_clk) begin
        r_sq1  <= r_f2;
        r_sq_p <= 62'(r_f2.x_mag) * 62'(r_f2.x_mag);
        if (!i_rst_n) begin
            r_sq1.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq2    <= r_sq1;
        r_sq2.x2 <= 32'(r_sq_p >> trs_pkg::WORK_FRAC) + 32'(r_sq_p[trs_pkg::WORK_FRAC-1]);
        if (!i_rst_n) begin
            r_sq2.valid <= 1'b0;
        end
    end

    assign term_bus[0] = r_sq2;

    // highest term first, down to the x^3 cell
    for (genvar i = 0; i < NCELL; i++) begin : g_term
        trs_term_cell #(
            .K(NCELL - i)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_bus  (term_bus[i]),
            .o_bus  (term_bus[i+1])
        );
    end

    // x times the nested sum
    assign fin_s_abs = term_bus[NCELL].s[31] ? 32'(-term_bus[NCELL].s)
                                             : 32'(term_bus[NCELL].s);

    always_ff @(posedge i_clk) begin
        r_fa_neg <= term_bus[NCELL].x_neg ^ term_bus[NCELL].s[31];
        r_fa_p   <= 63'(term_bus[NCELL].x_mag) * 63'(fin_s_abs);
        if (!i_rst_n) begin
            r_fa_valid <= 1'b0;
        end else begin
            r_fa_valid <= term_bus[NCELL].valid;
        end
    end

    // round to the output scale and saturate
    always_comb begin
        ym     = (r_fa_p >> Y_SH) + 63'(r_fa_p[Y_SH-1]);
        sat_m  = (ym > LIM) ? OUT_W'(LIM) : OUT_W'(ym);
        n_sine = r_fa_neg ? (-sat_m) : sat_m;
    end

    always_ff @(posedge i_clk) begin
        r_sine <= n_sine;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_fa_valid;
        end
    end

    assign o_strobe = r_strobe;
    assign o_sine   = $signed(r_sine);

    // every accepted word comes out as a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("result strobe missing after accepted angle");

    // result never beyond plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_sine <= $signed({1'b0, LIM[OUT_W-2:0]}))
                   && (o_sine >= -$signed({1'b0, LIM[OUT_W-2:0]}))))
        else $error("sine outside saturation range");

    // reduced angle within pi after rounding
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f2.valid |-> (r_f2.x_mag <= X_LIM))
        else $error("reduced angle magnitude above pi");

endmodule
